/* hw/rtl/ranging_frame_parser_macros.svh */
// ----------------------------------------------------------------------------
// Ranging frame parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef RANGING_FRAME_PARSER_MACROS_SVH
`define RANGING_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rfp assertion failed");

// next-cycle implication, disabled during reset
`define RFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rfp assertion failed");

`endif

/* hw/rtl/rfp_pkg.sv */
// ----------------------------------------------------------------------------
// Ranging frame parser package
// Beat types, sync phase encoding and frame constants.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h59;
    // sum of both header bytes, seed of the checksum
    localparam logic [7:0] HEADER_SUM  = HEADER_BYTE + HEADER_BYTE;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_DATA  = 2'd2
    } t_sync_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_beat;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] strength;
        logic [7:0]  quality;
        logic        status;
        logic [15:0] error_total;
    } t_result;

    // frame completion event from the sync stage
    typedef struct packed {
        logic        done;
        logic        good;
        logic [15:0] distance;
        logic [15:0] strength;
        logic [7:0]  quality;
    } t_frame_evt;

endpackage

/* hw/rtl/rfp_in_if.sv */
// ----------------------------------------------------------------------------
// Ranging frame parser input channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface rfp_in_if;
    logic              valid;
    logic              ready;
    rfp_pkg::t_rx_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/rfp_out_if.sv */
// ----------------------------------------------------------------------------
// Ranging frame parser result channel
// Valid/ready channel carrying one parsed measurement per beat.
// ----------------------------------------------------------------------------
interface rfp_out_if;
    logic             valid;
    logic             ready;
    rfp_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/rfp_frame_sync.sv */
// ----------------------------------------------------------------------------
// Ranging frame parser sync stage
// Header hunt, payload capture and running checksum.
// ----------------------------------------------------------------------------
`include "ranging_frame_parser_macros.svh"

module rfp_frame_sync #(
    parameter int FRAME_BYTES = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    output rfp_pkg::t_frame_evt o_evt
);
    import rfp_pkg::*;

    localparam int PAYLOAD_LEN = FRAME_BYTES - 1;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN);

    t_sync_phase      r_phase, n_phase;
    logic [IDX_W-1:0] r_index, n_index;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_distance, n_distance;
    logic [15:0]      r_strength, n_strength;
    logic [7:0]       r_quality, n_quality;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT2: n_phase = (i_rx_byte == HEADER_BYTE) ? PH_DATA : PH_HUNT1;
                PH_DATA:  n_phase = (r_index == LAST_IDX) ? PH_HUNT1 : PH_DATA;
                default:  n_phase = (i_rx_byte == HEADER_BYTE) ? PH_HUNT2 : PH_HUNT1;
            endcase
        end
    end

    // datapath and frame event
    always_comb begin
        n_index    = r_index;
        n_sum      = r_sum;
        n_distance = r_distance;
        n_strength = r_strength;
        n_quality  = r_quality;
        o_evt      = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (i_rx_byte == HEADER_BYTE) begin
                        n_index = '0;
                        n_sum   = HEADER_SUM;
                    end
                end
                PH_DATA: begin
                    if (r_index != LAST_IDX) begin
                        n_sum   = r_sum + i_rx_byte;
                        n_index = r_index + 1'b1;
                        if (r_index == IDX_W'(0)) n_distance[7:0]  = i_rx_byte;
                        if (r_index == IDX_W'(1)) n_distance[15:8] = i_rx_byte;
                        if (r_index == IDX_W'(2)) n_strength[7:0]  = i_rx_byte;
                        if (r_index == IDX_W'(3)) n_strength[15:8] = i_rx_byte;
                        if (r_index == IDX_W'(5)) n_quality        = i_rx_byte;
                    end else begin
                        // checksum byte
                        n_index        = '0;
                        o_evt.done     = 1'b1;
                        o_evt.good     = (i_rx_byte == r_sum);
                        o_evt.distance = r_distance;
                        o_evt.strength = r_strength;
                        o_evt.quality  = r_quality;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_index <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_index <= n_index;
            r_sum   <= n_sum;
        end
    end

    // captured payload fields, no reset
    always_ff @(posedge i_clk) begin
        r_distance <= n_distance;
        r_strength <= n_strength;
        r_quality  <= n_quality;
    end

    `RFP_ASSERT_NOW(a_idx_idle_zero, i_clk, i_rst_n, r_phase != PH_DATA, r_index == '0)
    `RFP_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, 1'b1, r_index <= LAST_IDX)
    `RFP_ASSERT_NEXT(a_done_rehunt, i_clk, i_rst_n, o_evt.done, r_phase == PH_HUNT1)

endmodule

/* hw/rtl/rfp_result_reg.sv */
// ----------------------------------------------------------------------------
// Ranging frame parser result stage
// Error tally and registered result beat.
// ----------------------------------------------------------------------------
`include "ranging_frame_parser_macros.svh"

module rfp_result_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfp_pkg::t_frame_evt i_evt,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output rfp_pkg::t_result    o_result,
    output logic                o_slot_free
);
    import rfp_pkg::*;

    logic        r_valid, n_valid;
    logic [15:0] r_tally, n_tally;
    t_result     r_result, n_result;

    always_comb begin
        n_valid  = r_valid && !i_out_ready;
        n_tally  = r_tally;
        n_result = r_result;
        if (i_evt.done) begin
            n_valid = 1'b1;
            if (i_evt.good) begin
                n_result.distance = i_evt.distance;
                n_result.strength = i_evt.strength;
                n_result.quality  = i_evt.quality;
                n_result.status   = 1'b0;
            end else begin
                n_tally           = r_tally + 16'd1;
                n_result.distance = '0;
                n_result.strength = '0;
                n_result.quality  = '0;
                n_result.status   = 1'b1;
            end
            n_result.error_total = n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tally <= '0;
        end else begin
            r_valid <= n_valid;
            r_tally <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;
    assign o_slot_free = !r_valid || i_out_ready;

    `RFP_ASSERT_NEXT(a_bad_bumps, i_clk, i_rst_n, i_evt.done && !i_evt.good,
                     r_tally == $past(r_tally) + 16'd1 && r_result.status)
    `RFP_ASSERT_NEXT(a_evt_shows, i_clk, i_rst_n, i_evt.done, r_valid)
    `RFP_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, i_evt.done, o_slot_free)

endmodule

/* hw/rtl/ranging_frame_parser.sv */
// ----------------------------------------------------------------------------
// Ranging frame parser
// The result register captures a frame's result beat when its checksum byte is accepted.
// Throughput: one received byte per cycle; while the sink stalls with the
// result register full, input ready is low and no new byte is taken.
// Reset: synchronous active low; clears phase, index, sum, tally and valid.
// Two-header serial frame parser with an 8-bit additive checksum check.
// ----------------------------------------------------------------------------
module ranging_frame_parser #(
    parameter int FRAME_BYTES = 7
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfp_in_if.sink    i_rx,
    rfp_out_if.source o_res
);
    import rfp_pkg::*;

    logic       r_run;      // holds ready low through reset
    logic       accept;
    logic       slot_free;
    t_frame_evt evt;
    t_result    result;
    logic       res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    // take a byte whenever the result register can absorb a possible result
    assign i_rx.ready = r_run && slot_free;
    assign accept     = i_rx.valid && i_rx.ready;

    // header hunt, payload capture, checksum compare
    rfp_frame_sync #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_sync (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx.data.rx_byte),
        .o_evt     (evt)
    );

    // error tally and output register
    rfp_result_reg u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_out_ready (o_res.ready),
        .o_out_valid (res_valid),
        .o_result    (result),
        .o_slot_free (slot_free)
    );

    assign o_res.valid = res_valid;
    assign o_res.data  = result;

endmodule

/* bench/tb_ranging_frame_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ranging frame parser testbench
// Drives received bytes through the input channel and checks every result
// beat against a cycle-free predictor of the double-header checksum parser.
// Directed frames cover extreme payloads, header slips and a checksum byte
// equal to the header. Further tests cover full-rate traffic, a long result
// back-pressure stretch and mostly well-formed random traffic mixed with
// noise.
// ----------------------------------------------------------------------------
module tb_ranging_frame_parser;
    import rfp_pkg::*;

    localparam int FRAME_BYTES  = 7;
    localparam int PAYLOAD_LEN  = FRAME_BYTES - 1;
    localparam int REPORT_LIMIT = 50;
    localparam int DRAIN_LIMIT  = 20000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rfp_in_if  rx_if ();
    rfp_out_if res_if ();

    ranging_frame_parser #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // predictor state, mirrors the parser
    t_sync_phase sync_ph    = PH_HUNT1;
    int          pay_cnt    = 0;
    logic [7:0]  pay_bytes [PAYLOAD_LEN];
    logic [7:0]  frame_sum  = '0;
    logic [15:0] fail_tally = '0;

    t_result pending_results [$];
    int      err_count = 0;

    // sender burst shaping and receiver stall knobs
    int gap_max    = 0;
    int burst_max  = 1;
    int burst_left = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int sent_bytes = 0;

    task automatic report_mismatch(input string what);
        if (err_count < REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // advance the predicted parser by one accepted byte
    task automatic track_rx_byte(input logic [7:0] b);
        t_result r;
        case (sync_ph)
            PH_HUNT2: begin
                if (b == HEADER_BYTE) begin
                    sync_ph   = PH_DATA;
                    pay_cnt   = 0;
                    frame_sum = HEADER_SUM;
                end else begin
                    // a bad second header is not a new first header
                    sync_ph = PH_HUNT1;
                end
            end
            PH_DATA: begin
                if (pay_cnt < PAYLOAD_LEN) begin
                    pay_bytes[pay_cnt] = b;
                    frame_sum          = frame_sum + b;
                    pay_cnt++;
                end else begin
                    sync_ph = PH_HUNT1;
                    pay_cnt = 0;
                    r       = '0;
                    if (b == frame_sum) begin
                        r.distance = {pay_bytes[1], pay_bytes[0]};
                        r.strength = {pay_bytes[3], pay_bytes[2]};
                        r.quality  = pay_bytes[5];
                    end else begin
                        fail_tally = fail_tally + 16'd1;
                        r.status   = 1'b1;
                    end
                    r.error_total = fail_tally;
                    pending_results.push_back(r);
                end
            end
            default: begin
                sync_ph = (b == HEADER_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    endtask

    // one input beat; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        rx_if.valid        <= 1'b1;
        rx_if.data.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        track_rx_byte(b);
        burst_left--;
        sent_bytes++;
        @(negedge clk);
    endtask

    // two headers, six payload bytes (byte 0 in the low bits), checksum
    task automatic send_frame(input logic [47:0] payload, input bit bad_sum);
        logic [7:0] sum;
        sum = HEADER_SUM;
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            sum = sum + payload[8*i +: 8];
            send_byte(payload[8*i +: 8]);
        end
        if (bad_sum) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        send_byte(sum);
    endtask

    function automatic logic [47:0] random_payload();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // sender idles until every expected beat has come out
    task automatic wait_results_done();
        int waited;
        waited = 0;
        rx_if.valid <= 1'b0;
        burst_left  = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    // receiver: long hold-off when requested, else random stalls
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_pct == 0) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result checker
    always @(posedge clk) begin : result_check
        t_result got_r;
        t_result want_r;
        if (rst_n && res_if.valid && res_if.ready) begin
            got_r = res_if.data;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", got_r));
            end else begin
                want_r = pending_results.pop_front();
                check_field("distance", got_r.distance, want_r.distance);
                check_field("strength", got_r.strength, want_r.strength);
                check_field("quality", 16'(got_r.quality), 16'(want_r.quality));
                check_field("status", 16'(got_r.status), 16'(want_r.status));
                check_field("error_total", got_r.error_total, want_r.error_total);
            end
        end
    end

    // all-ones payload with a broken checksum, then an all-zero good frame
    task automatic test_extreme_frames();
        gap_max   = 2;
        burst_max = 4;
        stall_pct = 20;
        send_frame({6{8'hFF}}, 1'b1);
        send_frame({6{8'h00}}, 1'b0);
        wait_results_done();
    endtask

    // bad second header, then a frame whose first payload byte is a header
    // and whose checksum also equals the header value
    task automatic test_header_slips();
        send_byte(HEADER_BYTE);
        send_byte(8'hA6);
        send_frame({32'h0, 8'h4E, HEADER_BYTE}, 1'b0);
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h59 + 8'h59 + 8'h59 + 8'h80);
        wait_results_done();
    endtask

    // back-to-back frames, no gaps on either side
    task automatic test_full_rate();
        gap_max   = 0;
        burst_max = 1;
        stall_pct = 0;
        for (int i = 0; i < 20; i++) begin
            send_frame(random_payload(), ($urandom_range(0, 3) == 0));
        end
        wait_results_done();
    endtask

    // result sink held off while frames keep coming, so the input stalls
    task automatic test_output_backpressure();
        stall_pct = 0;
        gap_max   = 0;
        hold_left = 300;
        for (int i = 0; i < 8; i++) begin
            send_frame(random_payload(), ($urandom_range(0, 1) == 0));
        end
        wait_results_done();
    endtask

    // mostly well-formed frames, some noise and broken header sequences
    task automatic test_random_traffic(input int n_bytes);
        int kind;
        int retune_at;
        retune_at = sent_bytes;
        n_bytes   = sent_bytes + n_bytes;
        while (sent_bytes < n_bytes) begin
            if (sent_bytes >= retune_at) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 35;
                    default: stall_pct = 70;
                endcase
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 12;
                endcase
                burst_max = $urandom_range(1, 16);
                retune_at = sent_bytes + 150;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(random_payload(), 1'b0);
            end else if (kind < 80) begin
                send_frame(random_payload(), 1'b1);
            end else if (kind < 88) begin
                send_byte(($urandom_range(0, 3) == 0) ? HEADER_BYTE
                                                       : 8'($urandom_range(0, 255)));
            end else if (kind < 95) begin
                send_byte(HEADER_BYTE);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                // lone header in front of a real frame
                send_byte(HEADER_BYTE);
                send_frame(random_payload(), 1'b0);
            end
        end
        wait_results_done();
    endtask

    initial begin
        rx_if.valid        = 1'b0;
        rx_if.data.rx_byte = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_extreme_frames();
        test_header_slips();
        test_full_rate();
        test_output_backpressure();
        test_random_traffic(380);
        test_random_traffic(380);

        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end
        repeat (20) @(negedge clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit, well above the slowest correct run
    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
